FILE: hdl/tensor_axis_reduce_defines.svh
// Assertion macros shared by the tensor_axis_reduce checker.
`ifndef TENSOR_AXIS_REDUCE_DEFINES_SVH
`define TENSOR_AXIS_REDUCE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TRD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TRD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/trd_pkg.sv
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package trd_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_AXES  = 4;
    localparam int AXIS_W    = 2;
    localparam int DIM_W     = 9;
    localparam int COORD_W   = 8;
    localparam int OUT_DEPTH = 1024;
    localparam int ADDR_W    = 10;
    localparam int RED_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam int RANK_W    = 3;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = 32;

    localparam logic [2:0] MODE_SUM  = 3'd0;
    localparam logic [2:0] MODE_MEAN = 3'd1;
    localparam logic [2:0] MODE_PROD = 3'd2;
    localparam logic [2:0] MODE_MAX  = 3'd3;
    localparam logic [2:0] MODE_MIN  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM3    = 3'd6;

    localparam logic OPC_ACC  = 1'b0;
    localparam logic OPC_READ = 1'b1;

    typedef struct packed {
        logic capture;
        logic step;
        logic acc_wr;
        logic res_load;
        logic div_step;
        logic out_load;
    } trd_cmd_t;

    typedef struct packed {
        logic is_read;
        logic last_axis;
        logic is_mean;
        logic err;
        logic div_last;
        logic out_busy;
    } trd_stat_t;

endpackage

FILE: hdl/tensor_axis_reduce.sv
// Top level: tensor axis reduction (sum, mean, product, max, min).
`timescale 1ns / 1ps
// Elements arrive row-major, one per transfer; the block walks the configured axes
// one per cycle to form the output address, then does a read-modify-write of the
// accumulator RAM. An accumulate ends with a RAM read and then the write. A read
// ends with a load of the stored value and, in mean mode, a pass through the
// bit-serial divider; a finished result waits in the output register while the
// next transfer is accepted. No clearing pass is needed after reset.
module tensor_axis_reduce (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trd_pkg::DIM_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic signed [trd_pkg::DATA_W-1:0] element_value,
    input  logic [trd_pkg::ADDR_W-1:0]        read_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [trd_pkg::DATA_W-1:0] result_value,
    output logic                              tensor_complete,
    output logic                              index_error
);

    trd_pkg::trd_cmd_t  cmd;
    trd_pkg::trd_stat_t stat;

    trd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    trd_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .element_value   (element_value),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_value    (result_value),
        .tensor_complete (tensor_complete),
        .index_error     (index_error),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

FILE: hdl/trd_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module trd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/trd_datapath.sv
// Datapath: configuration, coordinates, address walk, accumulator RAM, divider, output.
`timescale 1ns / 1ps
module trd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trd_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                opcode,
    input  logic signed [trd_pkg::DATA_W-1:0]   element_value,
    input  logic [trd_pkg::ADDR_W-1:0]          read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [trd_pkg::DATA_W-1:0]   result_value,
    output logic                                tensor_complete,
    output logic                                index_error,
    input  trd_pkg::trd_cmd_t                   cmd,
    output trd_pkg::trd_stat_t                  stat
);

    localparam int DW = trd_pkg::DATA_W;
    localparam int NA = trd_pkg::NUM_AXES;

    logic [2:0]                     op_mode_reg;
    logic [trd_pkg::RANK_W-1:0]     rank_reg;
    logic [NA-1:0]                  mask_reg;
    logic [trd_pkg::DIM_W-1:0]      dim_reg [NA];
    logic [trd_pkg::COORD_W-1:0]    coord_reg [NA];
    logic [trd_pkg::COORD_W-1:0]    coord_next [NA];
    logic                           complete_reg, complete_next;

    logic                           opc_reg;
    logic [DW-1:0]                  elem_reg;
    logic [trd_pkg::ADDR_W-1:0]     idx_reg;

    logic [trd_pkg::AXIS_W-1:0]     axis_reg;
    logic [trd_pkg::ADDR_W-1:0]     addr_reg;
    logic                           ovf_reg;
    logic [trd_pkg::RED_W-1:0]      red_reg;
    logic                           first_reg;

    logic [DW-1:0]                  res_reg;
    logic [DW-1:0]                  quo_reg;
    logic [trd_pkg::RED_W-1:0]      rem_reg;
    logic                           neg_reg;
    logic [trd_pkg::CNT_W-1:0]      cnt_reg;

    logic                           out_valid_reg;
    logic [DW-1:0]                  out_val_reg;
    logic                           out_cmp_reg;
    logic                           out_err_reg;

    logic [trd_pkg::RANK_W-1:0]     rank_eff;
    logic [trd_pkg::DIM_W-1:0]      dim_eff [NA];
    logic [trd_pkg::DIM_W-1:0]      cur_dim;
    logic [trd_pkg::COORD_W-1:0]    cur_coord;
    logic [trd_pkg::ADDR_W+trd_pkg::DIM_W:0] addr_prod;
    logic [trd_pkg::RED_W-1:0]      red_prod;
    logic [trd_pkg::ADDR_W-1:0]     ram_addr;
    logic [DW-1:0]                  ram_rdata;
    logic [DW-1:0]                  comb_val;
    logic [2*DW-1:0]                mul_full;
    logic [trd_pkg::RED_W:0]        rem_sh;
    logic [trd_pkg::RED_W:0]        rem_sub;
    logic [DW-1:0]                  quo_fin;
    logic                           carry;

    always_comb
    begin
        if (rank_reg == '0)
            rank_eff = trd_pkg::RANK_W'(1);
        else if (rank_reg > trd_pkg::RANK_W'(NA))
            rank_eff = trd_pkg::RANK_W'(NA);
        else
            rank_eff = rank_reg;
        for (int a = 0; a < NA; a++)
        begin
            if (dim_reg[a] == '0)
                dim_eff[a] = trd_pkg::DIM_W'(1);
            else if (dim_reg[a] > trd_pkg::DIM_W'(256))
                dim_eff[a] = trd_pkg::DIM_W'(256);
            else
                dim_eff[a] = dim_reg[a];
        end
    end

    // Odometer advance over the axes in use, innermost first.
    always_comb
    begin
        carry = 1'b1;
        for (int a = NA - 1; a >= 0; a--)
        begin
            coord_next[a] = coord_reg[a];
            if ((trd_pkg::RANK_W'(a) < rank_eff) && carry)
            begin
                if ({1'b0, coord_reg[a]} + trd_pkg::DIM_W'(1) < dim_eff[a])
                begin
                    coord_next[a] = coord_reg[a] + trd_pkg::COORD_W'(1);
                    carry = 1'b0;
                end
                else
                begin
                    coord_next[a] = '0;
                end
            end
        end
        complete_next = carry;
    end

    // One axis per step of the address walk.
    assign cur_dim   = dim_eff[axis_reg];
    assign cur_coord = (opc_reg == trd_pkg::OPC_READ) ? '0 : coord_reg[axis_reg];
    assign addr_prod = (trd_pkg::ADDR_W + trd_pkg::DIM_W + 1)'(addr_reg * cur_dim)
                     + (trd_pkg::ADDR_W + trd_pkg::DIM_W + 1)'(cur_coord);
    assign red_prod  = trd_pkg::RED_W'(red_reg * cur_dim);

    assign ram_addr = (opc_reg == trd_pkg::OPC_READ) ? idx_reg : addr_reg;

    trd_ram #(.WIDTH(DW), .DEPTH(trd_pkg::OUT_DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.acc_wr && !ovf_reg),
        .addr  (ram_addr),
        .wdata (comb_val),
        .rdata (ram_rdata)
    );

    assign mul_full = ram_rdata * elem_reg;

    always_comb
    begin
        comb_val = elem_reg;
        if (!first_reg)
        begin
            case (op_mode_reg)
                trd_pkg::MODE_PROD: comb_val = mul_full[DW-1:0];
                trd_pkg::MODE_MAX:
                    comb_val = ($signed(ram_rdata) < $signed(elem_reg)) ? elem_reg : ram_rdata;
                trd_pkg::MODE_MIN:
                    comb_val = ($signed(elem_reg) < $signed(ram_rdata)) ? elem_reg : ram_rdata;
                default: comb_val = ram_rdata + elem_reg;
            endcase
        end
    end

    // Restoring divider, one quotient bit a cycle.
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, red_reg};
    assign quo_fin = neg_reg ? (~quo_reg + DW'(1)) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg   <= trd_pkg::MODE_SUM;
            rank_reg      <= trd_pkg::RANK_W'(1);
            mask_reg      <= '1;
            for (int a = 0; a < NA; a++)
            begin
                dim_reg[a]   <= trd_pkg::DIM_W'(1);
                coord_reg[a] <= '0;
            end
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == trd_pkg::CFG_OP_MODE)
                    op_mode_reg <= cfg_data[2:0];
                else if (cfg_index <= trd_pkg::CFG_DIM3)
                begin
                    if (cfg_index == trd_pkg::CFG_RANK)
                        rank_reg <= cfg_data[trd_pkg::RANK_W-1:0];
                    else if (cfg_index == trd_pkg::CFG_MASK)
                        mask_reg <= cfg_data[NA-1:0];
                    else
                        dim_reg[trd_pkg::AXIS_W'(cfg_index - trd_pkg::CFG_DIM0)] <= cfg_data;
                    for (int a = 0; a < NA; a++)
                        coord_reg[a] <= '0;
                    complete_reg <= 1'b0;
                end
            end
            if (cmd.acc_wr)
            begin
                for (int a = 0; a < NA; a++)
                    coord_reg[a] <= coord_next[a];
                complete_reg <= complete_next;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opc_reg   <= opcode;
            elem_reg  <= element_value;
            idx_reg   <= read_index;
            axis_reg  <= '0;
            // a read walks the kept extents to form the kept-position count
            addr_reg  <= (opcode == trd_pkg::OPC_READ) ? trd_pkg::ADDR_W'(1) : '0;
            ovf_reg   <= 1'b0;
            red_reg   <= trd_pkg::RED_W'(1);
            first_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            axis_reg <= axis_reg + trd_pkg::AXIS_W'(1);
            if (mask_reg[axis_reg])
            begin
                red_reg <= red_prod;
                if (cur_coord != '0)
                    first_reg <= 1'b0;
            end
            else if (!ovf_reg)
            begin
                if (addr_prod >= (trd_pkg::ADDR_W + trd_pkg::DIM_W + 1)'(trd_pkg::OUT_DEPTH))
                    ovf_reg <= 1'b1;
                else
                    addr_reg <= addr_prod[trd_pkg::ADDR_W-1:0];
            end
        end
        if (cmd.res_load)
        begin
            res_reg <= stat.err ? '0 : ram_rdata;
            neg_reg <= ram_rdata[DW-1];
            quo_reg <= ram_rdata[DW-1] ? (~ram_rdata + DW'(1)) : ram_rdata;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + trd_pkg::CNT_W'(1);
            if (!rem_sub[trd_pkg::RED_W])
            begin
                rem_reg <= rem_sub[trd_pkg::RED_W-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[trd_pkg::RED_W-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_val_reg <= (stat.is_mean && !stat.err) ? quo_fin : res_reg;
            out_cmp_reg <= complete_reg;
            out_err_reg <= stat.err;
        end
    end

    assign stat.is_read   = (opc_reg == trd_pkg::OPC_READ);
    assign stat.last_axis = ({1'b0, axis_reg} == trd_pkg::RANK_W'(rank_eff - trd_pkg::RANK_W'(1)));
    assign stat.is_mean   = (op_mode_reg == trd_pkg::MODE_MEAN);
    assign stat.err       = !ovf_reg && (idx_reg >= addr_reg);
    assign stat.div_last  = (cnt_reg == trd_pkg::CNT_W'(trd_pkg::DIV_STEPS - 1));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign result_value    = out_val_reg;
    assign tensor_complete = out_cmp_reg;
    assign index_error     = out_err_reg;

endmodule

FILE: hdl/trd_ctrl.sv
// Controller: sequences the address walk, accumulator update and read path.
`timescale 1ns / 1ps
module trd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output trd_pkg::trd_cmd_t  cmd,
    input  trd_pkg::trd_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_DAT,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.last_axis)
                    state_next = stat.is_read ? S_RD_DAT : S_ACC_RD;
            end
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_DAT:
            begin
                cmd.res_load = 1'b1;
                state_next   = (stat.is_mean && !stat.err) ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

FILE: hdl/trd_checker.sv
// Port-level checker for tensor_axis_reduce, bound to the top level.
`timescale 1ns / 1ps
`include "tensor_axis_reduce_defines.svh"
module trd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              opcode,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [trd_pkg::DATA_W-1:0] result_value,
    input logic                              index_error
);

    `TRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value), "result changed while stalled")
    `TRD_ASSERT_ALWAYS(a_err_zero, !(out_valid && index_error) || (result_value == '0), "index error with nonzero value")
    `TRD_ASSERT_NEXT(a_acc_silent, in_valid && in_ready && (opcode == trd_pkg::OPC_ACC) && !out_valid, !out_valid, "accumulate produced a result")
    `TRD_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "transfer accepted while busy")

endmodule

bind tensor_axis_reduce trd_checker u_trd_checker (.*);
